[hw/rtl/dwu_pkg.sv]
// Shared types, constants and helpers of the digitizer waveform unpacker.
// Used by the output interface, the front, the back and the top level; no dependencies.
package dwu_pkg;

	// Default width of the run length field.
	localparam int unsigned DEFAULT_RUN_WIDTH = 26;
	// Width of the word count in a ZLE control word.
	localparam int unsigned BLOCK_CNT_W = 21;
	// Control word bit that marks a kept block.
	localparam int unsigned CTRL_KEPT_BIT = 31;
	// Entries of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZLE_ENABLE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 1'd1;

	typedef enum logic [1:0] {
		FMT_8  = 2'd0,
		FMT_10 = 2'd1,
		FMT_16 = 2'd2,
		FMT_32 = 2'd3
	} smp_fmt_t;

	localparam smp_fmt_t FMT_RESET = FMT_16;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_CONTROL = 2'd1,
		PH_DATA    = 2'd2
	} phase_t;

	// One classified word, as handed from the front to the back.
	// Results come out in the order: leading fill, samples, trailing fill, closing run.
	typedef struct packed {
		logic [31:0] word;
		smp_fmt_t    fmt;
		logic [2:0]  nsamp;
		logic        fill_en;
		logic        fill_pre;
		logic        fill_sat;
		logic        close_en;
		logic [31:0] aux_val;
		logic        lerr;
		logic        last;
		logic [2:0]  nres;
	} dwu_job_t;

	// Sample idx of a word, low bits first.
	function automatic logic [31:0] sample_at(input logic [31:0] word, input smp_fmt_t fmt,
			input logic [1:0] idx);
		logic [31:0] v;
		v = '0;
		case (fmt)
			FMT_8: begin
				v = {24'd0, word[8*idx +: 8]};
			end
			FMT_10: begin
				case (idx)
					2'd0: v = {22'd0, word[9:0]};
					2'd1: v = {22'd0, word[19:10]};
					default: v = {22'd0, word[29:20]};
				endcase
			end
			FMT_16: begin
				v = idx[0] ? {16'd0, word[31:16]} : {16'd0, word[15:0]};
			end
			default: begin
				v = word;
			end
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/dwu_in_if.sv]
// Input channel of the digitizer waveform unpacker: one 32-bit word per transaction.
// Depends on nothing.
interface dwu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        last_word;

	modport source (output valid, output data_word, output last_word, input ready);
	modport sink (input valid, input data_word, input last_word, output ready);
endinterface

[hw/rtl/dwu_out_if.sv]
// Output channel of the digitizer waveform unpacker: one run per transaction.
// Depends on dwu_pkg for the default run width.
interface dwu_out_if import dwu_pkg::*; #(
	parameter int unsigned RUN_WIDTH = DEFAULT_RUN_WIDTH
);
	logic                 valid;
	logic                 ready;
	logic [31:0]          sample_value;
	logic [RUN_WIDTH-1:0] run_length;
	logic                 is_fill;
	logic                 run_saturated;
	logic                 length_error;
	logic                 last;

	modport source (output valid, output sample_value, output run_length, output is_fill,
		output run_saturated, output length_error, output last, input ready);
	modport sink (input valid, input sample_value, input run_length, input is_fill,
		input run_saturated, input length_error, input last, output ready);
endinterface

[hw/rtl/digitizer_waveform_unpacker.sv]
// Top level of the digitizer waveform unpacker: configuration registers, front, queue, back.
// Depends on dwu_pkg, dwu_in_if, dwu_out_if, dwu_fifo, dwu_front and dwu_back.
//
// Channel     Direction  Transaction carries
// words       in         data_word (32), last_word (1)
// runs        out        sample_value (32), run_length (RUN_WIDTH), is_fill, run_saturated,
//                        length_error, last
// cfg         in         cfg_wr_en, cfg_index, cfg_wdata (write only, no handshake)
//
// The front takes one word per cycle while the queue has room. Each word makes zero to
// five runs (a data word makes four or five for 8-bit samples, one or two for 32-bit
// samples), and the back sequencer gives out one run per cycle while the output is not
// stalled; header and control words that make no run stay in the front and are not queued.
// Reset clears the channel state, the queue and the output valid flag; nothing else needs
// a clearing pass. A stalled output holds its run while the front keeps filling the queue.
module digitizer_waveform_unpacker import dwu_pkg::*; #(
	parameter int unsigned RUN_WIDTH = DEFAULT_RUN_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	dwu_in_if.sink                 words,
	dwu_out_if.source              runs,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);
	// A queue entry is the job descriptor plus the fill length, whose width follows
	// the run width.
	localparam int unsigned Q_WIDTH = RUN_WIDTH + $bits(dwu_job_t);

	logic                 zle_en_q;
	smp_fmt_t             fmt_q;

	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_empty;
	dwu_job_t             job_in;
	dwu_job_t             job_out;
	logic [RUN_WIDTH-1:0] len_in;
	logic [RUN_WIDTH-1:0] len_out;
	logic [Q_WIDTH-1:0]   q_rd;

	// Configuration must be written only while the block is idle; the block does not enforce
	// this, so the user must keep to it, and the registers feed the front directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zle_en_q <= 1'b0;
			fmt_q <= FMT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ZLE_ENABLE: zle_en_q <= cfg_wdata[0];
				CFG_SAMPLE_FORMAT: fmt_q <= smp_fmt_t'(cfg_wdata[1:0]);
				default: begin
				end
			endcase
		end
	end

	// The front classifies each word and keeps the ZLE channel state up to date.
	dwu_front #(
		.RUN_WIDTH(RUN_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.words(words),
		.zle_en(zle_en_q),
		.fmt_cfg(fmt_q),
		.q_full(q_full),
		.push(push),
		.job(job_in),
		.fill_len(len_in)
	);

	// The queue lets the front run ahead while the back works through multi-run words
	// or waits on a stalled output.
	dwu_fifo #(
		.WIDTH(Q_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data({len_in, job_in}),
		.pop(pop),
		.rd_data(q_rd),
		.full(q_full),
		.empty(q_empty)
	);

	assign job_out = dwu_job_t'(q_rd[$bits(dwu_job_t)-1:0]);
	assign len_out = q_rd[Q_WIDTH-1 -: RUN_WIDTH];

	// The back emits the runs of the head job in order and pops it after the last one.
	dwu_back #(
		.RUN_WIDTH(RUN_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.job(job_out),
		.fill_len(len_out),
		.pop(pop),
		.runs(runs)
	);
endmodule

[hw/rtl/dwu_fifo.sv]
// Small register queue between the front and the back of the unpacker.
// Depends on nothing; width and depth are parameters.
module dwu_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

[hw/rtl/dwu_front.sv]
// Front of the unpacker: accepts words, tracks the ZLE channel state and turns each
// word into a job for the back. Depends on dwu_pkg and dwu_in_if.
module dwu_front import dwu_pkg::*; #(
	parameter int unsigned RUN_WIDTH = DEFAULT_RUN_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dwu_in_if.sink               words,
	input  logic                 zle_en,
	input  smp_fmt_t             fmt_cfg,
	input  logic                 q_full,
	output logic                 push,
	output dwu_job_t             job,
	output logic [RUN_WIDTH-1:0] fill_len
);
	localparam int unsigned SUB_W = BLOCK_CNT_W + 2;
	localparam int unsigned SUM_W = ((RUN_WIDTH > SUB_W) ? RUN_WIDTH : SUB_W) + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'((64'd1 << RUN_WIDTH) - 64'd1);
	localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

	phase_t                 phase_q, phase_n;
	logic [31:0]            seen_q, seen_n;
	logic [31:0]            decl_q, decl_n;
	logic [BLOCK_CNT_W-1:0] blk_q, blk_n;
	logic [RUN_WIDTH-1:0]   pend_q, pend_n;
	logic                   clamp_q, clamp_n;
	logic                   have_q, have_n;
	logic [31:0]            kept_q, kept_n;

	logic                   accept;
	logic [31:0]            w;
	smp_fmt_t               zfmt;
	logic [2:0]             spw;
	logic [1:0]             spw_shift;
	logic [BLOCK_CNT_W-1:0] sub;
	logic [SUM_W-1:0]       gap_sum;
	logic                   gap_sat;
	logic [31:0]            fillv;

	assign words.ready = !q_full;
	assign accept = words.valid && !q_full;
	assign w = words.data_word;
	assign sub = w[BLOCK_CNT_W-1:0];
	// ZLE data has no packed format; the 10-bit setting reads it as 16-bit samples.
	assign zfmt = (fmt_cfg == FMT_10) ? FMT_16 : fmt_cfg;

	always_comb begin
		case (zfmt)
			FMT_8: begin
				spw = 3'd4;
				spw_shift = 2'd2;
			end
			FMT_32: begin
				spw = 3'd1;
				spw_shift = 2'd0;
			end
			default: begin
				spw = 3'd2;
				spw_shift = 2'd1;
			end
		endcase
	end

	assign gap_sum = SUM_W'(pend_q) + (SUM_W'(sub) << spw_shift);
	assign gap_sat = (gap_sum > SUM_MAX);

	always_comb begin
		phase_n = phase_q;
		seen_n = seen_q;
		decl_n = decl_q;
		blk_n = blk_q;
		pend_n = pend_q;
		clamp_n = clamp_q;
		have_n = have_q;
		kept_n = kept_q;
		fillv = '0;
		job = '0;
		fill_len = '0;
		job.word = w;
		if (zle_en) begin
			job.fmt = zfmt;
			case (phase_q)
				PH_CONTROL: begin
					seen_n = seen_q + 32'd1;
					if (w[CTRL_KEPT_BIT]) begin
						if (sub != '0) begin
							blk_n = sub;
							phase_n = PH_DATA;
						end
					end else begin
						pend_n = gap_sat ? RUN_MAX : gap_sum[RUN_WIDTH-1:0];
						if (gap_sat) begin
							clamp_n = 1'b1;
						end
					end
				end
				PH_DATA: begin
					seen_n = seen_q + 32'd1;
					job.nsamp = spw;
					if (pend_q != '0) begin
						// The gap takes the value of the first kept sample after it.
						job.fill_en = 1'b1;
						job.fill_pre = 1'b1;
						job.fill_sat = clamp_q;
						job.aux_val = sample_at(w, zfmt, 2'd0);
						fill_len = pend_q;
						pend_n = '0;
						clamp_n = 1'b0;
					end
					kept_n = sample_at(w, zfmt, 2'(spw - 3'd1));
					have_n = 1'b1;
					blk_n = blk_q - 1'b1;
					if (blk_n == '0) begin
						phase_n = PH_CONTROL;
					end
				end
				default: begin
					decl_n = w;
					seen_n = 32'd1;
					blk_n = '0;
					pend_n = '0;
					clamp_n = 1'b0;
					have_n = 1'b0;
					kept_n = '0;
					phase_n = PH_CONTROL;
				end
			endcase
			if (seen_n >= decl_n) begin
				fillv = have_n ? kept_n : 32'd1;
				job.lerr = (blk_n != '0);
				if (pend_n != '0) begin
					job.fill_en = 1'b1;
					job.fill_pre = 1'b0;
					job.fill_sat = clamp_n;
					job.aux_val = fillv;
					fill_len = pend_n;
				end else if (job.nsamp == 3'd0) begin
					job.close_en = 1'b1;
					job.aux_val = fillv;
				end
				job.last = 1'b1;
				phase_n = PH_HEADER;
				blk_n = '0;
				pend_n = '0;
				clamp_n = 1'b0;
			end
		end else begin
			job.fmt = fmt_cfg;
			case (fmt_cfg)
				FMT_8: job.nsamp = 3'd4;
				FMT_10: job.nsamp = {1'b0, w[31:30]};
				FMT_16: job.nsamp = 3'd2;
				default: job.nsamp = 3'd1;
			endcase
			job.close_en = words.last_word && (job.nsamp == 3'd0);
			job.last = words.last_word;
		end
		job.nres = job.nsamp + {2'd0, job.fill_en} + {2'd0, job.close_en};
		push = accept && (job.nres != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			seen_q <= '0;
			decl_q <= '0;
			blk_q <= '0;
			pend_q <= '0;
			clamp_q <= 1'b0;
			have_q <= 1'b0;
			kept_q <= '0;
		end else if (accept && zle_en) begin
			phase_q <= phase_n;
			seen_q <= seen_n;
			decl_q <= decl_n;
			blk_q <= blk_n;
			pend_q <= pend_n;
			clamp_q <= clamp_n;
			have_q <= have_n;
			kept_q <= kept_n;
		end
	end
endmodule

[hw/rtl/dwu_back.sv]
// Back of the unpacker: moves the job at the queue head into the output register,
// one run per cycle unless the output stalls. Depends on dwu_pkg and dwu_out_if.
module dwu_back import dwu_pkg::*; #(
	parameter int unsigned RUN_WIDTH = DEFAULT_RUN_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  dwu_job_t             job,
	input  logic [RUN_WIDTH-1:0] fill_len,
	output logic                 pop,
	dwu_out_if.source            runs
);
	logic [2:0]           pos_q;
	logic                 out_valid_q;
	logic [31:0]          value_q;
	logic [RUN_WIDTH-1:0] len_q;
	logic                 fill_q;
	logic                 sat_q;
	logic                 lerr_q;
	logic                 last_q;

	logic                 advance;
	logic                 emit;
	logic                 lead_fill;
	logic [2:0]           j;
	logic                 final_res;
	logic [31:0]          value_d;
	logic [RUN_WIDTH-1:0] len_d;
	logic                 fill_d;
	logic                 sat_d;

	assign advance = !out_valid_q || runs.ready;
	assign emit = advance && !q_empty;
	assign final_res = (pos_q == job.nres - 3'd1);
	assign pop = emit && final_res;

	assign lead_fill = job.fill_en && job.fill_pre;
	assign j = pos_q - {2'd0, lead_fill};

	always_comb begin
		value_d = job.aux_val;
		len_d = '0;
		fill_d = 1'b0;
		sat_d = 1'b0;
		if (lead_fill && (pos_q == 3'd0)) begin
			len_d = fill_len;
			fill_d = 1'b1;
			sat_d = job.fill_sat;
		end else if (j < job.nsamp) begin
			value_d = sample_at(job.word, job.fmt, j[1:0]);
			len_d = RUN_WIDTH'(1);
		end else if (job.fill_en) begin
			len_d = fill_len;
			fill_d = 1'b1;
			sat_d = job.fill_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !q_empty;
			if (emit) begin
				pos_q <= final_res ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= value_d;
			len_q <= len_d;
			fill_q <= fill_d;
			sat_q <= sat_d;
			lerr_q <= final_res && job.lerr;
			last_q <= final_res && job.last;
		end
	end

	assign runs.valid = out_valid_q;
	assign runs.sample_value = value_q;
	assign runs.run_length = len_q;
	assign runs.is_fill = fill_q;
	assign runs.run_saturated = sat_q;
	assign runs.length_error = lerr_q;
	assign runs.last = last_q;
endmodule

[bench/tb_digitizer_waveform_unpacker.sv]
// Self-checking bench for the digitizer waveform unpacker: raw and zero-length-encoded channels.
// Depends on dwu_pkg, dwu_in_if, dwu_out_if and the digitizer_waveform_unpacker top level.
`timescale 1ns / 100ps

import dwu_pkg::*;

localparam int unsigned RUNW = DEFAULT_RUN_WIDTH;
localparam logic [63:0] RUN_MAX = (64'd1 << RUNW) - 64'd1;

typedef logic [31:0] word_q_t[$];

// One run as it leaves the block.
typedef struct packed {
	logic [31:0]     value;
	logic [RUNW-1:0] len;
	logic            fill;
	logic            sat;
	logic            lerr;
	logic            last;
} run_t;

// Tracks the channel state of the unpacker, works out the runs that every accepted word
// must produce and holds them until they come out of the block.
class run_book;
	run_t        expected_runs[$];
	int unsigned mismatches;

	bit          zle_on;
	smp_fmt_t    fmt;
	phase_t      phase;
	logic [31:0] seen;
	logic [31:0] declared;
	logic [BLOCK_CNT_W-1:0] block_left;
	logic [RUNW-1:0] gap;
	bit          gap_sat;
	bit          have_kept;
	logic [31:0] last_kept;

	function new();
		mismatches = 0;
		zle_on = 1'b0;
		fmt = FMT_RESET;
		phase = PH_HEADER;
		seen = '0;
		declared = '0;
		block_left = '0;
		gap = '0;
		gap_sat = 1'b0;
		have_kept = 1'b0;
		last_kept = '0;
	endfunction

	function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == CFG_ZLE_ENABLE)
			zle_on = val[0];
		else if (idx == CFG_SAMPLE_FORMAT)
			fmt = smp_fmt_t'(val);
	endfunction

	function int width_of();
		if (fmt == FMT_8)
			return 8;
		if (fmt == FMT_32)
			return 32;
		return 16;
	endfunction

	function logic [31:0] pick(logic [31:0] w, int bits, int i);
		case (bits)
			8: return {24'd0, w[8*i +: 8]};
			10: return {22'd0, w[10*i +: 10]};
			16: return {16'd0, w[16*i +: 16]};
			default: return w;
		endcase
	endfunction

	function run_t make_run(logic [31:0] v, logic [RUNW-1:0] l, bit f, bit s);
		run_t r;
		r.value = v;
		r.len = l;
		r.fill = f;
		r.sat = s;
		r.lerr = 1'b0;
		r.last = 1'b0;
		return r;
	endfunction

	function void take_word(logic [31:0] w, bit lastw);
		run_t        batch[$];
		int          bits;
		int          spw;
		logic [63:0] g;
		logic [31:0] s;
		logic [31:0] fillv;

		bits = width_of();
		spw = 32 / bits;
		s = '0;
		if (!zle_on) begin
			if (fmt == FMT_10) begin
				for (int i = 0; i < int'(w[31:30]); i++)
					batch.insert(batch.size(),
						make_run(pick(w, 10, i), RUNW'(1), 1'b0, 1'b0));
			end else begin
				for (int i = 0; i < spw; i++)
					batch.insert(batch.size(),
						make_run(pick(w, bits, i), RUNW'(1), 1'b0, 1'b0));
			end
			if (lastw) begin
				if (batch.size() == 0)
					batch.insert(batch.size(), make_run('0, '0, 1'b0, 1'b0));
				batch[batch.size()-1].last = 1'b1;
			end
		end else begin
			case (phase)
				PH_CONTROL: begin
					seen++;
					if (w[CTRL_KEPT_BIT]) begin
						// A kept block of zero words leaves the phase unchanged.
						if (w[BLOCK_CNT_W-1:0] != 0) begin
							block_left = w[BLOCK_CNT_W-1:0];
							phase = PH_DATA;
						end
					end else begin
						g = 64'(gap) + 64'(w[BLOCK_CNT_W-1:0]) * 64'(spw);
						if (g > RUN_MAX) begin
							g = RUN_MAX;
							gap_sat = 1'b1;
						end
						gap = g[RUNW-1:0];
					end
				end
				PH_DATA: begin
					seen++;
					for (int i = 0; i < spw; i++) begin
						s = pick(w, bits, i);
						if (i == 0 && gap != 0) begin
							batch.insert(batch.size(), make_run(s, gap, 1'b1, gap_sat));
							gap = '0;
							gap_sat = 1'b0;
						end
						batch.insert(batch.size(), make_run(s, RUNW'(1), 1'b0, 1'b0));
					end
					last_kept = s;
					have_kept = 1'b1;
					block_left = block_left - 1'b1;
					if (block_left == 0)
						phase = PH_CONTROL;
				end
				default: begin
					declared = w;
					seen = 32'd1;
					block_left = '0;
					gap = '0;
					gap_sat = 1'b0;
					have_kept = 1'b0;
					last_kept = '0;
					phase = PH_CONTROL;
				end
			endcase
			if (seen >= declared) begin
				fillv = have_kept ? last_kept : 32'd1;
				if (gap != 0)
					batch.insert(batch.size(), make_run(fillv, gap, 1'b1, gap_sat));
				if (batch.size() == 0)
					batch.insert(batch.size(), make_run(fillv, '0, 1'b0, 1'b0));
				batch[batch.size()-1].lerr = (block_left != 0);
				batch[batch.size()-1].last = 1'b1;
				phase = PH_HEADER;
				block_left = '0;
				gap = '0;
				gap_sat = 1'b0;
			end
		end
		foreach (batch[i])
			expected_runs.insert(expected_runs.size(), batch[i]);
	endfunction

	function void match_run(run_t got);
		run_t want;
		if (expected_runs.size() == 0) begin
			$display("%0t: unexpected run: value=%h len=%0d fill=%b sat=%b lerr=%b last=%b",
				$time, got.value, got.len, got.fill, got.sat, got.lerr, got.last);
			mismatches++;
			return;
		end
		want = expected_runs.pop_front();
		if (got !== want) begin
			$display("%0t: run mismatch: expected value=%h len=%0d fill=%b sat=%b lerr=%b last=%b",
				$time, want.value, want.len, want.fill, want.sat, want.lerr, want.last);
			$display("%0t:                 actual value=%h len=%0d fill=%b sat=%b lerr=%b last=%b",
				$time, got.value, got.len, got.fill, got.sat, got.lerr, got.last);
			mismatches++;
		end
	endfunction

	function int outstanding();
		return expected_runs.size();
	endfunction
endclass

module tb_digitizer_waveform_unpacker;

	// Generous bound on the whole run.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Cycles allowed after the last expected run for words that make no run.
	localparam int unsigned SETTLE_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	dwu_in_if word_bus();
	dwu_out_if #(.RUN_WIDTH(RUNW)) run_bus();

	digitizer_waveform_unpacker #(.RUN_WIDTH(RUNW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.words(word_bus),
		.runs(run_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	run_book     book = new();
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	// Idling odds out of eight per transaction; zero gives stretches without any idling.
	int unsigned gap_odds = 0;
	int unsigned stall_odds = 0;
	// Set for the closing part of the run, where neither side idles.
	bit          calm = 1'b0;
	// Rest of a ZLE channel that was cut short at the end of a phase.
	word_q_t     channel_tail;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[digitizer_waveform_unpacker] ERROR");
			$finish;
		end
	end

	// Runs are checked at the falling edge, where valid and ready are settled; a run seen
	// with both high there is taken by the rising edge that follows.
	always @(negedge clk) begin : watch_runs
		run_t got;
		if (arst_n && run_bus.valid && run_bus.ready) begin
			got.value = run_bus.sample_value;
			got.len = run_bus.run_length;
			got.fill = run_bus.is_fill;
			got.sat = run_bus.run_saturated;
			got.lerr = run_bus.length_error;
			got.last = run_bus.last;
			book.match_run(got);
		end
	end

	// Receiver: holds ready low in random bursts, unless calm is set.
	initial begin
		run_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!calm && stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
				run_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			run_bus.ready <= 1'b1;
		end
	end

	// Offers one word, possibly after an idle burst, and returns at the rising edge that
	// accepts it. The caller is at a rising edge, and so is this task when it returns, so
	// a following word keeps valid high without lowering it in between.
	task automatic send_word(input logic [31:0] w, input bit lw);
		bit took;
		if (!calm && gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
			word_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		word_bus.valid <= 1'b1;
		word_bus.data_word <= w;
		word_bus.last_word <= lw;
		do begin
			@(negedge clk);
			took = word_bus.ready;
			if (!took)
				@(posedge clk);
		end while (!took);
		book.take_word(w, lw);
		items_sent++;
		@(posedge clk);
	endtask

	// The last-word flag means nothing in ZLE mode, so it is left to chance there.
	task automatic send_zle(input word_q_t q);
		foreach (q[i])
			send_word(q[i], 1'($urandom_range(0, 1)));
	endtask

	// Stops offering words and waits until every expected run has been taken, then waits out
	// SETTLE_CYCLES for header and control words still on their way through the front.
	task automatic quiesce();
		word_bus.valid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		book.set_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Builds one well-formed ZLE channel: header, then a mix of gaps, kept blocks with
	// their data words and empty kept blocks. Now and then the header is cut short, which
	// gives empty channels and kept blocks that run past the declared count. A saturating
	// shape piles up nine maximal gaps before one kept word.
	task automatic build_channel(output word_q_t q, input bit saturate);
		word_q_t body;
		int      hdr;
		int      k;
		logic [BLOCK_CNT_W-1:0] cnt;
		q = {};
		if (saturate || $urandom_range(0, 15) == 0) begin
			repeat (9) body.insert(body.size(), {1'b0, 10'($urandom), 21'h1F_FFFF});
			body.insert(body.size(), {1'b1, 10'($urandom), 21'd1});
			body.insert(body.size(), $urandom);
		end else begin
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 5))
					0, 1: begin
						cnt = ($urandom_range(0, 3) == 0) ? 21'($urandom)
							: 21'($urandom_range(0, 12));
						body.insert(body.size(), {1'b0, 10'($urandom), cnt});
					end
					2: begin
						body.insert(body.size(), {1'b1, 10'($urandom), 21'd0});
					end
					default: begin
						k = $urandom_range(1, 3);
						body.insert(body.size(), {1'b1, 10'($urandom), 21'(k)});
						repeat (k) body.insert(body.size(), $urandom);
					end
				endcase
			end
		end
		hdr = body.size() + 1;
		if ($urandom_range(0, 7) == 0)
			hdr = $urandom_range(0, hdr);
		q.insert(q.size(), 32'(hdr));
		for (int i = 0; i < hdr - 1; i++)
			q.insert(q.size(), body[i]);
	endtask

	initial begin : stimulus
		word_q_t     q;
		int unsigned phase_items;
		int unsigned target;
		int          cut;
		bit          zle_sel;
		logic [1:0]  fmt_sel;

		arst_n <= 1'b0;
		word_bus.valid <= 1'b0;
		word_bus.data_word <= '0;
		word_bus.last_word <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_ZLE_ENABLE;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with light idling on both sides.
		gap_odds = 2;
		stall_odds = 2;

		// Raw 16-bit samples straight out of reset, both halves at their extremes.
		send_word(32'hFFFF_0000, 1'b0);
		send_word(32'h0000_FFFF, 1'b1);

		quiesce();
		write_reg(CFG_SAMPLE_FORMAT, FMT_8);
		send_word(32'h80FF_7F01, 1'b1);

		// Packed 10-bit: a full word of three samples, then a final word that carries no
		// sample at all and so must close the channel with an empty run.
		quiesce();
		write_reg(CFG_SAMPLE_FORMAT, FMT_10);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h3FFF_FFFF, 1'b1);

		quiesce();
		write_reg(CFG_SAMPLE_FORMAT, FMT_32);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h0000_0000, 1'b0);

		// ZLE with 16-bit samples. Headers of zero and one give empty channels.
		quiesce();
		write_reg(CFG_ZLE_ENABLE, 2'b01);
		write_reg(CFG_SAMPLE_FORMAT, FMT_16);
		send_zle({32'd0});
		send_zle({32'd1});

		// A leading gap, an empty kept block that must be skipped, and a kept block that
		// claims more words than the header leaves, so the channel ends with a length error.
		send_zle({32'd5, 32'h0000_0003, 32'h8000_0000, 32'h8000_0005, 32'h1234_5678});

		// A trailing gap with no kept sample at all is filled with one.
		send_zle({32'd2, 32'h0000_0007});

		// Nine maximal gaps of 8-bit samples overflow the run field at the channel's end.
		quiesce();
		write_reg(CFG_SAMPLE_FORMAT, FMT_8);
		q = {32'd10};
		repeat (9) q.insert(q.size(), 32'h001F_FFFF);
		send_zle(q);

		// Random part. Every phase starts from an idle block with fresh register values; the
		// first eight phases walk through every mode and format. A ZLE phase may stop in the
		// middle of a channel, which then resumes in the next ZLE phase, possibly after raw
		// phases and a format change.
		for (int p = 0; items_sent < 140; p++) begin
			quiesce();
			if (p < 8) begin
				zle_sel = p[0];
				fmt_sel = p[2:1];
			end else begin
				zle_sel = 1'($urandom_range(0, 2) != 0);
				fmt_sel = 2'($urandom);
			end
			write_reg(CFG_ZLE_ENABLE, {1'($urandom), zle_sel});
			write_reg(CFG_SAMPLE_FORMAT, fmt_sel);
			calm = (items_sent > 115);
			gap_odds = $urandom_range(0, 4);
			stall_odds = $urandom_range(0, 4);
			target = $urandom_range(12, 28);
			phase_items = 0;
			if (!zle_sel) begin
				repeat (target)
					send_word($urandom, 1'($urandom_range(0, 7) == 0));
			end else begin
				phase_items = channel_tail.size();
				send_zle(channel_tail);
				channel_tail = {};
				while (phase_items < target) begin
					build_channel(q, phase_items == 0 && fmt_sel == FMT_8);
					if (phase_items + q.size() > target && q.size() > 1 &&
							$urandom_range(0, 1) == 1) begin
						cut = $urandom_range(1, q.size() - 1);
						while (q.size() > cut)
							channel_tail.push_front(q.pop_back());
					end
					phase_items += q.size();
					send_zle(q);
				end
			end
		end

		quiesce();
		if (book.mismatches == 0 && book.outstanding() == 0) begin
			$display("[digitizer_waveform_unpacker] OK");
		end else begin
			$display("[digitizer_waveform_unpacker] ERROR");
		end
		$finish;
	end

endmodule

[digitizer_waveform_unpacker.f]
hw/rtl/dwu_pkg.sv
hw/rtl/dwu_in_if.sv
hw/rtl/dwu_out_if.sv
hw/rtl/dwu_fifo.sv
hw/rtl/dwu_front.sv
hw/rtl/dwu_back.sv
hw/rtl/digitizer_waveform_unpacker.sv
bench/tb_digitizer_waveform_unpacker.sv
